@@ hdl/gapm_pkg.sv @@
// Shared types and constants for the gamepad autofire port mapper.
// Used by gapm_autofire, gapm_player and gamepad_autofire_port_mapper_core.
package gapm_pkg;

  localparam int BUTTON_COUNT       = 4;
  localparam int PAD_BITS           = 4;
  // Only buttons A to D reach the port, so only those lanes carry a counter.
  localparam int AF_LANES           = (BUTTON_COUNT < PAD_BITS) ? BUTTON_COUNT : PAD_BITS;
  localparam int CNT_W              = 8;
  localparam int COMBO_COUNT        = 11;
  localparam int LOCK_W             = 5;
  localparam logic [LOCK_W-1:0] SWAP_LOCKOUT_TICKS = LOCK_W'(30);

  localparam int CFG_IDX_W          = 8;
  localparam int CFG_DATA_W         = 8;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_INTERVAL  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_AUTOFIRE_ENABLE = CFG_IDX_W'(1);

  localparam logic [CNT_W-1:0]    PULSE_INTERVAL_RST  = CNT_W'(1);
  localparam logic [PAD_BITS-1:0] AUTOFIRE_ENABLE_RST = PAD_BITS'(15);

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  localparam logic [7:0] COMBO_MASKS [COMBO_COUNT] = '{
    8'hcf, 8'haf, 8'h6f, 8'h9f, 8'h5f, 8'h3f, 8'h8f, 8'h4f, 8'h2f, 8'h1f, 8'h0f
  };

  // One frame tick; the last member lands in the lowest bits of tdata.
  typedef struct packed {
    logic                   swap_key;
    logic                   select_key;
    logic                   start_key;
    logic [COMBO_COUNT-1:0] combo_keys;
    logic [PAD_BITS-1:0]    turbo_keys;
    logic [PAD_BITS-1:0]    button_keys;
    logic [PAD_BITS-1:0]    direction_keys;
  } tick_t;

  typedef struct packed {
    logic       active_player;
    logic [3:0] system_port;
    logic [7:0] player_two_port;
    logic [7:0] player_one_port;
  } result_t;

  // Control handed from the pipeline to the state-holding units.
  typedef struct packed {
    logic step;
    logic swap;
  } step_ctl_t;

endpackage

@@ hdl/gapm_autofire.sv @@
// Per-button autofire pulse counters and button substitution.
// Depends on gapm_pkg.
module gapm_autofire (
  input  logic                             clk,
  input  logic                             rst_n,
  input  gapm_pkg::step_ctl_t              ctl,
  input  logic [gapm_pkg::CNT_W-1:0]       pulse_interval,
  input  logic [gapm_pkg::PAD_BITS-1:0]    autofire_enable,
  input  logic [gapm_pkg::PAD_BITS-1:0]    button_keys,
  input  logic [gapm_pkg::PAD_BITS-1:0]    turbo_keys,
  output logic [gapm_pkg::PAD_BITS-1:0]    buttons_out
);

  logic [gapm_pkg::CNT_W-1:0] cnt_r   [gapm_pkg::AF_LANES];
  logic [gapm_pkg::CNT_W-1:0] cnt_nxt [gapm_pkg::AF_LANES];

  always_comb begin
    logic [gapm_pkg::CNT_W:0] inc;
    buttons_out = button_keys;
    for (int i = 0; i < gapm_pkg::AF_LANES; i++) begin
      cnt_nxt[i] = cnt_r[i];
      inc        = {1'b0, cnt_r[i]} + (gapm_pkg::CNT_W+1)'(1);
      if (autofire_enable[i]) begin
        if (turbo_keys[i]) begin
          buttons_out[i] = (cnt_r[i] == '0);
          cnt_nxt[i]     = (inc > {1'b0, pulse_interval}) ? '0 : inc[gapm_pkg::CNT_W-1:0];
        end else begin
          cnt_nxt[i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < gapm_pkg::AF_LANES; i++) begin
      if (!rst_n) begin
        cnt_r[i] <= '0;
      end else if (ctl.step) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

endmodule

@@ hdl/gapm_player.sv @@
// Player selection with swap lockout, hotkey masking and port byte mapping.
// Depends on gapm_pkg.
module gapm_player (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gapm_pkg::step_ctl_t                 ctl,
  input  logic [gapm_pkg::PAD_BITS-1:0]       direction_keys,
  input  logic [gapm_pkg::PAD_BITS-1:0]       buttons,
  input  logic [gapm_pkg::COMBO_COUNT-1:0]    combo_keys,
  input  logic                                start_key,
  input  logic                                select_key,
  output gapm_pkg::result_t                   result
);

  logic                        sel_r, sel_nxt;
  logic [gapm_pkg::LOCK_W-1:0] lock_r, lock_nxt;
  logic [7:0]                  port_byte;

  always_comb begin
    port_byte = ~{buttons, direction_keys};
    for (int k = 0; k < gapm_pkg::COMBO_COUNT; k++) begin
      if (combo_keys[k]) port_byte = port_byte & gapm_pkg::COMBO_MASKS[k];
    end
  end

  // Swap loads the lockout and it counts down on the same tick.
  always_comb begin
    sel_nxt  = sel_r;
    lock_nxt = (lock_r != '0) ? lock_r - gapm_pkg::LOCK_W'(1) : '0;
    if (ctl.swap && lock_r == '0) begin
      sel_nxt  = ~sel_r;
      lock_nxt = gapm_pkg::SWAP_LOCKOUT_TICKS - gapm_pkg::LOCK_W'(1);
    end
  end

  // Ports follow the selection from before this tick's swap.
  always_comb begin
    result.active_player = sel_nxt;
    if (sel_r) begin
      result.player_one_port = 8'hff;
      result.player_two_port = port_byte;
      result.system_port     = {~select_key, ~start_key, 2'b11};
    end else begin
      result.player_one_port = port_byte;
      result.player_two_port = 8'hff;
      result.system_port     = {2'b11, ~select_key, ~start_key};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r  <= 1'b0;
      lock_r <= '0;
    end else if (ctl.step) begin
      sel_r  <= sel_nxt;
      lock_r <= lock_nxt;
    end
  end

  a_lock_range: assert property (@(posedge clk) disable iff (!rst_n)
    lock_r < gapm_pkg::SWAP_LOCKOUT_TICKS)
    else $error("swap lockout out of range");

  a_toggle_needs_idle_lock: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.step && sel_nxt != sel_r) |-> (lock_r == '0))
    else $error("player toggled during lockout");

  a_toggle_loads_lock: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.step && sel_nxt != sel_r) |=>
      (lock_r == gapm_pkg::SWAP_LOCKOUT_TICKS - gapm_pkg::LOCK_W'(1)))
    else $error("lockout not loaded on swap");

  a_hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.step |=> ($stable(sel_r) && $stable(lock_r)))
    else $error("player state moved without a tick");

endmodule

@@ hdl/gamepad_autofire_port_mapper_core.sv @@
// Top level of the gamepad autofire port mapper: input register, tick logic, result register.
// Depends on gapm_pkg, gapm_autofire and gapm_player.
//
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------------
//  in_      | sink      | one frame tick of pad flags
//  out_     | source    | port bytes, system port and active player per tick
//  cfg_     | sink      | register writes: 0 pulse_interval, 1 autofire_enable
//
// One item per clock sustained while out_ is not stalled; each result passes both registers.
// The input register feeds the counters and mapping logic, which fill the result register.
// A stall on out_ holds the input register; in_ keeps taking items while either register drains.
// rst_n (synchronous) clears counters, player, lockout, registers to their reset values.
// cfg_ready is always high; writes must come only while no tick is in flight.
module gamepad_autofire_port_mapper_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [3:0] direction_keys, [7:4] button_keys, [11:8] turbo_keys, [22:12] combo_keys,
  // [23] start_key, [24] select_key, [25] swap_key, [31:26] zero
  input  logic [gapm_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [7:0] player_one_port, [15:8] player_two_port, [19:16] system_port,
  // [20] active_player, [23:21] zero
  output logic [gapm_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gapm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gapm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int TICK_W = $bits(gapm_pkg::tick_t);
  localparam int RES_W  = $bits(gapm_pkg::result_t);

  logic [gapm_pkg::CNT_W-1:0]    pulse_interval_r;
  logic [gapm_pkg::PAD_BITS-1:0] autofire_enable_r;

  logic                 s1_valid_r;
  gapm_pkg::tick_t      s1_tick_r;
  logic                 out_valid_r;
  gapm_pkg::result_t    out_res_r;

  logic                 s1_adv;
  gapm_pkg::step_ctl_t  ctl;
  logic [gapm_pkg::PAD_BITS-1:0] buttons_eff;
  gapm_pkg::result_t    res_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_interval_r  <= gapm_pkg::PULSE_INTERVAL_RST;
      autofire_enable_r <= gapm_pkg::AUTOFIRE_ENABLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gapm_pkg::REG_PULSE_INTERVAL:  pulse_interval_r  <= cfg_data[gapm_pkg::CNT_W-1:0];
        gapm_pkg::REG_AUTOFIRE_ENABLE: autofire_enable_r <= cfg_data[gapm_pkg::PAD_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  assign ctl.step = s1_adv;
  assign ctl.swap = s1_tick_r.swap_key;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) s1_tick_r <= gapm_pkg::tick_t'(in_tdata[TICK_W-1:0]);
  end

  gapm_autofire u_autofire (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .pulse_interval  (pulse_interval_r),
    .autofire_enable (autofire_enable_r),
    .button_keys     (s1_tick_r.button_keys),
    .turbo_keys      (s1_tick_r.turbo_keys),
    .buttons_out     (buttons_eff)
  );

  gapm_player u_player (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .direction_keys (s1_tick_r.direction_keys),
    .buttons        (buttons_eff),
    .combo_keys     (s1_tick_r.combo_keys),
    .start_key      (s1_tick_r.start_key),
    .select_key     (s1_tick_r.select_key),
    .result         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) out_res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(gapm_pkg::OUT_TDATA_W-RES_W)'(0), out_res_r};

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_res_r)))
    else $error("result changed under stall");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken with both stages full");

  a_step_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step |-> s1_valid_r)
    else $error("state stepped without an item");

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for gamepad_autofire_port_mapper_core: a tick-level port model
// predicts every result, with random tick bursts, receiver stalls and register phases.
// Depends on gapm_pkg and the RTL of the core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gapm_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 6;
  localparam int LONG_RUN_CHURN = 1000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = CFG_IDX_W'(255);

  typedef enum logic { PLAYER_ONE, PLAYER_TWO } player_e;
  typedef enum logic [1:0] { RX_OPEN, RX_RANDOM, RX_PATTERN } rx_mode_e;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gamepad_autofire_port_mapper_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Port model state
  logic [CNT_W-1:0] pulse_limit;
  logic [PAD_BITS-1:0] af_mask;
  logic [CNT_W-1:0] af_count [PAD_BITS];
  player_e cur_player;
  logic [LOCK_W-1:0] swap_hold;

  result_t expected_ports [$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  int burst_left = 0;
  bit steady = 1'b0;
  rx_mode_e rx_mode = RX_OPEN;
  logic [7:0] rx_phase = '0;

  // Advances the model by one tick and returns the ports it produces.
  function automatic result_t map_tick(tick_t t);
    logic [PAD_BITS-1:0] btn;
    logic [7:0] port;
    logic [3:0] sys;
    logic [CNT_W:0] bumped;
    result_t r;
    btn = t.button_keys;
    for (int i = 0; i < AF_LANES; i++) begin
      if (af_mask[i]) begin
        if (t.turbo_keys[i]) begin
          btn[i] = (af_count[i] == '0);
          bumped = {1'b0, af_count[i]} + 1'b1;
          af_count[i] = (bumped > {1'b0, pulse_limit}) ? '0 : bumped[CNT_W-1:0];
        end else begin
          af_count[i] = '0;
        end
      end
    end
    port = ~{btn, t.direction_keys};
    for (int k = 0; k < COMBO_COUNT; k++)
      if (t.combo_keys[k]) port &= COMBO_MASKS[k];
    sys = 4'hf;
    r = '0;
    if (cur_player == PLAYER_TWO) begin
      r.player_one_port = 8'hff;
      r.player_two_port = port;
      sys[2] = ~t.start_key;
      sys[3] = ~t.select_key;
    end else begin
      r.player_one_port = port;
      r.player_two_port = 8'hff;
      sys[0] = ~t.start_key;
      sys[1] = ~t.select_key;
    end
    r.system_port = sys;
    // ports above use the player from before this tick's swap
    if (t.swap_key && swap_hold == '0) begin
      cur_player = (cur_player == PLAYER_ONE) ? PLAYER_TWO : PLAYER_ONE;
      swap_hold = SWAP_LOCKOUT_TICKS;
    end
    if (swap_hold != '0) swap_hold = swap_hold - 1'b1;
    r.active_player = cur_player;
    return r;
  endfunction

  // Model update on register and tick transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      pulse_limit = PULSE_INTERVAL_RST;
      af_mask = AUTOFIRE_ENABLE_RST;
      for (int i = 0; i < PAD_BITS; i++) af_count[i] = '0;
      cur_player = PLAYER_ONE;
      swap_hold = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PULSE_INTERVAL:  pulse_limit = cfg_data[CNT_W-1:0];
          REG_AUTOFIRE_ENABLE: af_mask = cfg_data[PAD_BITS-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_ports.push_back(map_tick(tick_t'(in_tdata[$bits(tick_t)-1:0])));
    end
  end

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[$bits(result_t)-1:0]);
      if (expected_ports.size() == 0) begin
        flag_mismatch("unexpected result", 32'(out_tdata), '0);
      end else begin
        want = expected_ports.pop_front();
        if (got.player_one_port != want.player_one_port)
          flag_mismatch("player_one_port", 32'(got.player_one_port), 32'(want.player_one_port));
        if (got.player_two_port != want.player_two_port)
          flag_mismatch("player_two_port", 32'(got.player_two_port), 32'(want.player_two_port));
        if (got.system_port != want.system_port)
          flag_mismatch("system_port", 32'(got.system_port), 32'(want.system_port));
        if (got.active_player != want.active_player)
          flag_mismatch("active_player", 32'(got.active_player), 32'(want.active_player));
        if (out_tdata[OUT_TDATA_W-1:$bits(result_t)] != '0)
          flag_mismatch("tdata padding", 32'(out_tdata), '0);
      end
    end
  end

  // Receiver: long hold-off on request, otherwise the current stall pattern
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1'b1;
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_RANDOM: out_tready <= ($urandom_range(0, 3) != 0);
        default:   out_tready <= (rx_phase[2:0] != 3'd5) && (rx_phase[5:4] != 2'd3);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One tick transfer; valid stays up between back-to-back calls within a burst
  task automatic send_tick(tick_t t);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady && $urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'(t);
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop offering ticks and let every result come back
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_ports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic tick_t pad_tick(logic [3:0] dirs, logic [3:0] btns, logic [3:0] turbo,
                                     logic [COMBO_COUNT-1:0] combos, logic start, logic sel,
                                     logic swap);
    tick_t t;
    t.direction_keys = dirs;
    t.button_keys = btns;
    t.turbo_keys = turbo;
    t.combo_keys = combos;
    t.start_key = start;
    t.select_key = sel;
    t.swap_key = swap;
    return t;
  endfunction

  task automatic test_port_mapping();
    send_tick(pad_tick('0, '0, '0, '0, 1'b0, 1'b0, 1'b0));
    send_tick(pad_tick(4'hf, 4'hf, '0, '0, 1'b1, 1'b1, 1'b0));
    for (int k = 0; k < COMBO_COUNT; k++)
      send_tick(pad_tick(4'($urandom), '0, '0, COMBO_COUNT'(1) << k, k[0], k[1], 1'b0));
    send_tick(pad_tick('0, '0, '0, '1, 1'b1, 1'b0, 1'b0));
  endtask

  task automatic test_autofire_pulse();
    // default interval 1: pulse on, off, on; release clears the counter
    repeat (3) send_tick(pad_tick('0, '0, 4'hf, '0, 1'b0, 1'b0, 1'b0));
    send_tick(pad_tick('0, 4'hf, 4'h5, '0, 1'b0, 1'b0, 1'b0));
    send_tick(pad_tick('0, 4'ha, 4'hf, '0, 1'b0, 1'b0, 1'b0));
  endtask

  task automatic test_player_swap();
    // second press lands in the lockout; ports follow the old player
    send_tick(pad_tick(4'h3, 4'h9, '0, '0, 1'b1, 1'b0, 1'b1));
    send_tick(pad_tick(4'hc, 4'h6, '0, '0, 1'b1, 1'b1, 1'b1));
    send_tick(pad_tick(4'h5, 4'h0, '0, '0, 1'b0, 1'b1, 1'b0));
  endtask

  task automatic run_ticks(int n, int turbo_churn);
    tick_t t;
    logic [3:0] turbo;
    bit swap_run;
    bit long_run;
    long_run = (turbo_churn > LONG_RUN_CHURN);
    // long runs start with every autofire key held so the counters can wrap
    turbo = long_run ? 4'hf : 4'($urandom);
    swap_run = 1'b0;
    repeat (n) begin
      if ($urandom_range(0, turbo_churn) == 0) turbo = 4'($urandom);
      if ($urandom_range(0, 40) == 0) swap_run = ~swap_run;
      t = pad_tick(4'($urandom), 4'($urandom), turbo, '0, 1'($urandom), 1'($urandom),
                   swap_run || ($urandom_range(0, 5) == 0));
      case ($urandom_range(0, 3))
        0: t.combo_keys = COMBO_COUNT'($urandom);
        1: t.combo_keys = COMBO_COUNT'(1) << $urandom_range(0, COMBO_COUNT - 1);
        default: t.combo_keys = '0;
      endcase
      // occasional noise tick with the autofire keys scrambled
      if (!long_run && $urandom_range(0, 15) == 0) t.turbo_keys = 4'($urandom);
      send_tick(t);
    end
  endtask

  task automatic test_register_writes();
    cfg_write(REG_PULSE_INTERVAL, '0);
    cfg_write(REG_AUTOFIRE_ENABLE, 8'hff);
    cfg_write(REG_UNUSED_LO, 8'h55);
    cfg_write(REG_UNUSED_HI, 8'haa);
    run_ticks(20, 30);
  endtask

  task automatic test_random_phases();
    logic [7:0] limits [6] = '{8'd1, 8'd255, 8'd3, 8'd0, 8'd7, 8'd2};
    logic [7:0] masks [6] = '{8'h0f, 8'h0f, 8'h05, 8'h0a, 8'h00, 8'hf3};
    for (int p = 0; p < 6; p++) begin
      cfg_write(REG_PULSE_INTERVAL, (p == 4) ? 8'($urandom) : limits[p]);
      cfg_write(REG_AUTOFIRE_ENABLE, (p == 5) ? 8'($urandom) : masks[p]);
      rx_mode = rx_mode_e'(p % 3);
      steady = (p % 4 == 2);
      // the widest interval needs the autofire keys held past a full wrap
      if (limits[p] == 8'd255) run_ticks(600, 2000);
      else run_ticks(150, 25);
    end
    steady = 1'b0;
  endtask

  task automatic test_input_backpressure();
    settle();
    rx_mode = RX_OPEN;
    steady = 1'b1;
    hold_left = 300;
    run_ticks(60, 20);
    steady = 1'b0;
    rx_mode = RX_RANDOM;
    run_ticks(40, 10);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    out_tready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_port_mapping();
    test_autofire_pulse();
    test_player_swap();
    test_register_writes();
    test_random_phases();
    test_input_backpressure();
    settle();
    if (mismatches == 0 && expected_ports.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
